// ----- hw/rtl/aldfs_pkg.sv -----
`default_nettype none

package aldfs_pkg;

	// vertex numbering is fixed by the 4-bit vertex fields
	localparam int VtxW             = 4;
	localparam int MAX_VERTICES     = 16;
	localparam int CountW           = 5;
	localparam int MAX_ARCS_DEFAULT = 128;

	// input actions
	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// result codes
	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_VISITED = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_VERTEX_COUNT = 2'd0,
		REG_UNDIRECTED   = 2'd1
	} reg_index_t;

	typedef struct packed {
		action_t           action;
		logic [VtxW-1:0]   tail_vertex;
		logic [VtxW-1:0]   head_vertex;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [VtxW-1:0]   vertex;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [1:0]        index;
		logic [CountW-1:0] data;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ARC_FWD,
		S_ARC_REV,
		S_RESULT,
		S_ROOT,
		S_TOP,
		S_NEIGH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    ready;
		logic    add_arc;
		logic    add_rev;
		logic    clear_lists;
		logic    run_init;
		logic    root_next;
		logic    visit_root;
		logic    visit_nbr;
		logic    pop;
		logic    arc_read;
		logic    link_update;
		logic    emit;
		status_t emit_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic    req_valid;
		action_t action;
		logic    add_ok;
		logic    undirected;
		logic    root_done;
		logic    root_visited;
		logic    depth_zero;
		logic    depth_full;
		logic    top_empty;
		logic    nbr_new;
		logic    last_visit;
		logic    out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/aldfs_if.sv -----
`default_nettype none

// request channel
interface aldfs_req_if;
	logic                 valid;
	logic                 ready;
	aldfs_pkg::req_t      data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface aldfs_rsp_if;
	logic                 valid;
	logic                 ready;
	aldfs_pkg::rsp_t      data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// configuration write channel
interface aldfs_cfg_if;
	logic                 valid;
	logic                 ready;
	aldfs_pkg::cfg_t      data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adjacency_list_dfs_order_unit.sv -----
`default_nettype none

// channel  role  payload
// req      sink  action, tail_vertex, head_vertex
// rsp      src   status, vertex, last
// cfg      sink  index (0 vertex_count, 1 undirected), data
//
// one item at a time: accept, decode, then
//   add edge: store the arc and, when undirected, its reverse arc, then post the result
//   clear: empty the lists, then post the result
//   run: per arc examined, an arc store read, then visit; besides these, root steps,
//     stack pops and returns to the root scan
// the single read port of the arc store sets the walk rate
// async reset clears list heads, arc count, visited marks, walk depth; arc store is not reset
// a result waits in the output register while rsp.ready is low; the walk pauses on it

module adjacency_list_dfs_order_unit #(
	parameter int MAX_ARCS = aldfs_pkg::MAX_ARCS_DEFAULT
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	aldfs_req_if.sink    req,
	aldfs_rsp_if.source  rsp,
	aldfs_cfg_if.sink    cfg
);

	aldfs_pkg::cmd_t cmd;
	aldfs_pkg::sts_t sts;

	// sequencer
	aldfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// graph storage, walk state and output register
	aldfs_datapath #(
		.MAX_ARCS (MAX_ARCS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

`ifndef SYNTH
	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result posted while output register still held");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp.valid)
		else $error("posted result not presented");

	a_stack_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.visit_root || cmd.visit_nbr) |-> !sts.depth_full)
		else $error("walk stack overflow");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/aldfs_datapath.sv -----
`default_nettype none

module aldfs_datapath #(
	parameter int MAX_ARCS = aldfs_pkg::MAX_ARCS_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	aldfs_req_if.sink         req,
	aldfs_rsp_if.source       rsp,
	aldfs_cfg_if.sink         cfg,
	input  wire aldfs_pkg::cmd_t cmd,
	output aldfs_pkg::sts_t   sts
);

	localparam int VtxW   = aldfs_pkg::VtxW;
	localparam int CountW = aldfs_pkg::CountW;
	localparam int MaxV   = aldfs_pkg::MAX_VERTICES;
	localparam int AW     = $clog2(MAX_ARCS + 1);
	localparam int MW     = $clog2(MAX_ARCS);
	localparam int EW     = VtxW + AW;

	logic [CountW-1:0]   vcount_q;
	logic                undir_q;
	logic [CountW-1:0]   n_work;
	aldfs_pkg::req_t     item_q;
	logic [AW-1:0]       lh_q [MaxV];
	logic [AW-1:0]       used_q;
	logic [EW-1:0]       arc_mem [MAX_ARCS];
	logic [EW-1:0]       rd_q;
	logic [MaxV-1:0]     visited_q;
	logic [CountW-1:0]   root_q;
	logic [CountW-1:0]   depth_q;
	logic [CountW-1:0]   vcnt_q;
	logic [AW-1:0]       stack_arc_q [MaxV];
	aldfs_pkg::rsp_t     out_q;
	logic                out_valid_q;

	logic [VtxW-1:0]     rd_target;
	logic [AW-1:0]       rd_link;
	logic [VtxW-1:0]     top_idx;
	logic [AW-1:0]       top_arc;
	logic [VtxW-1:0]     lh_addr;
	logic [AW-1:0]       lh_rd;
	logic [VtxW-1:0]     from_v;
	logic [VtxW-1:0]     to_v;
	logic [VtxW-1:0]     vsel;
	logic                visit;
	logic [AW:0]         need;
	logic [AW-1:0]       arc_pos;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CountW'(MaxV);
			undir_q  <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.data.index == aldfs_pkg::REG_VERTEX_COUNT) begin
				vcount_q <= cfg.data.data;
			end
			if (cfg.data.index == aldfs_pkg::REG_UNDIRECTED) begin
				undir_q <= cfg.data.data[0];
			end
		end
	end

	// working vertex count, clamped to 1..MaxV
	always_comb begin
		if (vcount_q == '0) begin
			n_work = CountW'(1);
		end else if (vcount_q > CountW'(MaxV)) begin
			n_work = CountW'(MaxV);
		end else begin
			n_work = vcount_q;
		end
	end

	// input item capture
	assign req.ready = cmd.ready;

	always_ff @(posedge clk) begin
		if (req.valid && cmd.ready) begin
			item_q <= req.data;
		end
	end

	// arc endpoints for forward and reverse insertion
	assign from_v = cmd.add_rev ? item_q.head_vertex : item_q.tail_vertex;
	assign to_v   = cmd.add_rev ? item_q.tail_vertex : item_q.head_vertex;

	// visit target and list head read port
	assign rd_target = rd_q[EW-1 -: VtxW];
	assign rd_link   = rd_q[AW-1:0];
	assign visit     = cmd.visit_root || cmd.visit_nbr;
	assign vsel      = cmd.visit_root ? root_q[VtxW-1:0] : rd_target;
	assign lh_addr   = cmd.add_arc ? from_v : vsel;
	assign lh_rd     = lh_q[lh_addr];

	// list heads and arc allocation count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxV; i++) begin
				lh_q[i] <= '0;
			end
			used_q <= '0;
		end else if (cmd.clear_lists) begin
			for (int i = 0; i < MaxV; i++) begin
				lh_q[i] <= '0;
			end
			used_q <= '0;
		end else if (cmd.add_arc) begin
			lh_q[from_v] <= used_q + AW'(1);
			used_q       <= used_q + AW'(1);
		end
	end

	// arc store: target and link, one write and one registered read
	assign arc_pos = top_arc - AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.add_arc) begin
			arc_mem[used_q[MW-1:0]] <= {to_v, lh_rd};
		end
		if (cmd.arc_read) begin
			rd_q <= arc_mem[arc_pos[MW-1:0]];
		end
	end

	// walk control counters and visited marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			root_q    <= '0;
			depth_q   <= '0;
			vcnt_q    <= '0;
		end else if (cmd.run_init) begin
			visited_q <= '0;
			root_q    <= '0;
			depth_q   <= '0;
			vcnt_q    <= '0;
		end else begin
			if (cmd.root_next) begin
				root_q <= root_q + CountW'(1);
			end
			if (visit) begin
				visited_q[vsel] <= 1'b1;
				depth_q         <= depth_q + CountW'(1);
				vcnt_q          <= vcnt_q + CountW'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - CountW'(1);
			end
		end
	end

	// walk stack of next arc positions
	assign top_idx = VtxW'(depth_q - CountW'(1));
	assign top_arc = stack_arc_q[top_idx];

	always_ff @(posedge clk) begin
		if (cmd.link_update) begin
			stack_arc_q[top_idx] <= rd_link;
		end
		if (visit) begin
			stack_arc_q[depth_q[VtxW-1:0]] <= lh_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status <= cmd.emit_status;
			out_q.vertex <= visit ? vsel : '0;
			out_q.last   <= visit ? sts.last_visit : 1'b1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// status toward the controller
	assign need = undir_q ? (AW+1)'(2) : (AW+1)'(1);

	always_comb begin
		sts.req_valid    = req.valid;
		sts.action       = item_q.action;
		sts.add_ok       = ({1'b0, item_q.tail_vertex} < n_work)
			&& ({1'b0, item_q.head_vertex} < n_work)
			&& (({1'b0, used_q} + need) <= (AW+1)'(MAX_ARCS));
		sts.undirected   = undir_q;
		sts.root_done    = root_q >= n_work;
		sts.root_visited = visited_q[root_q[VtxW-1:0]];
		sts.depth_zero   = depth_q == '0;
		sts.depth_full   = depth_q == CountW'(MaxV);
		sts.top_empty    = top_arc == '0;
		sts.nbr_new      = ({1'b0, rd_target} < n_work) && !visited_q[rd_target];
		sts.last_visit   = vcnt_q == (n_work - CountW'(1));
		sts.out_free     = !out_valid_q || rsp.ready;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/aldfs_ctrl.sv -----
`default_nettype none

module aldfs_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire aldfs_pkg::sts_t sts,
	output aldfs_pkg::cmd_t   cmd
);

	aldfs_pkg::state_t  state_q;
	aldfs_pkg::state_t  state_d;
	aldfs_pkg::status_t res_status_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aldfs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one result code register for add, clear and unknown items
	always_ff @(posedge clk) begin
		if (state_q == aldfs_pkg::S_DECODE) begin
			case (sts.action)
				aldfs_pkg::ACT_ADD: begin
					res_status_q <= sts.add_ok ? aldfs_pkg::ST_STORED
						: aldfs_pkg::ST_DROPPED;
				end
				aldfs_pkg::ACT_CLEAR: begin
					res_status_q <= aldfs_pkg::ST_CLEARED;
				end
				default: begin
					res_status_q <= aldfs_pkg::ST_DROPPED;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aldfs_pkg::S_IDLE: begin
				if (sts.req_valid) state_d = aldfs_pkg::S_DECODE;
			end
			aldfs_pkg::S_DECODE: begin
				case (sts.action)
					aldfs_pkg::ACT_ADD: begin
						state_d = sts.add_ok ? aldfs_pkg::S_ARC_FWD : aldfs_pkg::S_RESULT;
					end
					aldfs_pkg::ACT_RUN: begin
						state_d = aldfs_pkg::S_ROOT;
					end
					default: begin
						state_d = aldfs_pkg::S_RESULT;
					end
				endcase
			end
			aldfs_pkg::S_ARC_FWD: begin
				state_d = sts.undirected ? aldfs_pkg::S_ARC_REV : aldfs_pkg::S_RESULT;
			end
			aldfs_pkg::S_ARC_REV: begin
				state_d = aldfs_pkg::S_RESULT;
			end
			aldfs_pkg::S_RESULT: begin
				if (sts.out_free) state_d = aldfs_pkg::S_IDLE;
			end
			aldfs_pkg::S_ROOT: begin
				if (sts.root_done) begin
					state_d = aldfs_pkg::S_IDLE;
				end else if (!sts.root_visited && sts.out_free) begin
					state_d = sts.last_visit ? aldfs_pkg::S_IDLE : aldfs_pkg::S_TOP;
				end
			end
			aldfs_pkg::S_TOP: begin
				if (sts.depth_zero) begin
					state_d = aldfs_pkg::S_ROOT;
				end else if (!sts.top_empty) begin
					state_d = aldfs_pkg::S_NEIGH;
				end
			end
			aldfs_pkg::S_NEIGH: begin
				if (!sts.nbr_new) begin
					state_d = aldfs_pkg::S_TOP;
				end else if (sts.out_free) begin
					state_d = sts.last_visit ? aldfs_pkg::S_IDLE : aldfs_pkg::S_TOP;
				end
			end
			default: begin
				state_d = aldfs_pkg::S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.emit_status = aldfs_pkg::ST_VISITED;
		case (state_q)
			aldfs_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
			end
			aldfs_pkg::S_DECODE: begin
				cmd.clear_lists = sts.action == aldfs_pkg::ACT_CLEAR;
				cmd.run_init    = sts.action == aldfs_pkg::ACT_RUN;
			end
			aldfs_pkg::S_ARC_FWD: begin
				cmd.add_arc = 1'b1;
			end
			aldfs_pkg::S_ARC_REV: begin
				cmd.add_arc = 1'b1;
				cmd.add_rev = 1'b1;
			end
			aldfs_pkg::S_RESULT: begin
				cmd.emit        = sts.out_free;
				cmd.emit_status = res_status_q;
			end
			aldfs_pkg::S_ROOT: begin
				cmd.root_next  = !sts.root_done && sts.root_visited;
				cmd.visit_root = !sts.root_done && !sts.root_visited && sts.out_free;
				cmd.emit       = cmd.visit_root;
			end
			aldfs_pkg::S_TOP: begin
				cmd.pop      = !sts.depth_zero && sts.top_empty;
				cmd.arc_read = !sts.depth_zero && !sts.top_empty;
			end
			aldfs_pkg::S_NEIGH: begin
				cmd.link_update = 1'b1;
				cmd.visit_nbr   = sts.nbr_new && sts.out_free;
				cmd.emit        = cmd.visit_nbr;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire
